// ===== src/ummt_pkg.sv =====
// ummt_pkg: shared types and constants of the unexpected message match table
// holds the request, result and record structs, the action codes and the fsm states
// no dependencies
`timescale 1ns / 1ps

package ummt_pkg;

  // bit widths fixed by the field formats
  localparam int ACTION_W = 2;
  localparam int COMM_W   = 16;
  localparam int RANK_W   = 31;
  localparam int TAG_W    = 31;
  localparam int SIZE_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int TCNT_W   = 4;

  // communicator plus offset fits in 17 bits, padded to whole digits for the divider
  localparam int DIG_W    = 4;
  localparam int DIVD_W   = 20;
  localparam int DIV_STEPS = DIVD_W / DIG_W;

  // table count after reset
  localparam logic [TCNT_W-1:0] TCNT_RESET = 4'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH      = 2'd0,
    ACT_PROBE     = 2'd1,
    ACT_POP_MATCH = 2'd2,
    ACT_POP_SLOT  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [COMM_W-1:0]   communicator;
    logic [RANK_W-1:0]   rank;
    logic                any_rank;
    logic [TAG_W-1:0]    tag;
    logic                any_tag;
    logic [SIZE_W-1:0]   msg_bytes;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [SIZE_W-1:0]   found_size;
    logic [SLOT_W-1:0]   found_slot;
  } rsp_t;

  // one cell as stored in memory
  typedef struct packed {
    logic                busy;
    logic [RANK_W-1:0]   rank;
    logic [TAG_W-1:0]    tag;
    logic [SIZE_W-1:0]   size;
  } rec_t;

endpackage

// ===== src/ummt_ram.sv =====
// ummt_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ummt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ummt_mod.sv =====
// ummt_mod: iterative remainder unit, four dividend bits per cycle
// depends on ummt_pkg for the dividend and digit widths
`timescale 1ns / 1ps

module ummt_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ummt_pkg::DIVD_W-1:0]   dividend,
  input  logic [3:0]                    divisor,
  output logic                          done,
  output logic [3:0]                    remainder
);

  localparam int CNT_W = $clog2(ummt_pkg::DIV_STEPS + 1);

  logic                          run;
  logic [CNT_W-1:0]              cnt;
  logic [ummt_pkg::DIVD_W-1:0]   shreg;
  logic [3:0]                    dsr;
  logic [3:0]                    rem_next;

  // restoring remainder over the top digit of the shift register
  always_comb begin
    logic [4:0] r;
    r = 5'd0;
    rem_next = remainder;
    for (int k = 0; k < ummt_pkg::DIG_W; k++) begin
      r = {rem_next, shreg[ummt_pkg::DIVD_W-1-k]};
      if (r >= {1'b0, dsr}) begin
        r = r - {1'b0, dsr};
      end
      rem_next = r[3:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ummt_pkg::DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dsr       <= divisor;
      remainder <= 4'd0;
    end else if (run) begin
      shreg     <= shreg << ummt_pkg::DIG_W;
      remainder <= rem_next;
    end
  end

endmodule

// ===== src/unexpected_message_match_table_core.sv =====
// unexpected_message_match_table_core: top level of the message match table
// depends on ummt_pkg, ummt_mod and ummt_ram
`timescale 1ns / 1ps

// Keeps TABLES tables of CELLS pending message records in one memory. A command
// is taken when start is high and busy is low; its result appears for one cycle
// with done high and cannot be held off. The table is picked as (communicator +
// HIDDEN_TABLES) mod the effective table_count, computed by a remainder unit.
// The scan then reads one cell per cycle from the memory and stops at the first
// fitting cell or after the last cell of its table; pop by slot reads at most
// the single cell of its slot. After reset a clearing pass writes every cell
// free, one per cycle, with busy high; cfg_we writes of table_count are taken
// at any time.
module unexpected_message_match_table_core #(
  parameter int CELLS         = 16,
  parameter int TABLES        = 8,
  parameter int HIDDEN_TABLES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ummt_pkg::req_t                request,
  output logic                          done,
  output ummt_pkg::rsp_t                result,
  input  logic                          cfg_we,
  input  logic [ummt_pkg::TCNT_W-1:0]   cfg_data
);

  localparam int TOTAL  = TABLES * CELLS;
  localparam int AW     = TOTAL > 1 ? $clog2(TOTAL) : 1;
  localparam int TW     = TABLES > 1 ? $clog2(TABLES) : 1;
  localparam int IW     = $clog2(CELLS + 1);
  localparam int REC_W  = $bits(ummt_pkg::rec_t);

  ummt_pkg::state_t             state, state_next;
  ummt_pkg::req_t               req;
  ummt_pkg::rec_t               rd_rec;
  ummt_pkg::rec_t               hit_rec;
  ummt_pkg::rec_t               wr_rec;
  logic [ummt_pkg::TCNT_W-1:0]  table_count;
  logic [3:0]                   tcount_eff;
  logic [TW-1:0]                tbl;
  logic [IW-1:0]                scan_idx;
  logic [IW-1:0]                last_idx;
  logic [IW-1:0]                pend_idx;
  logic [IW-1:0]                hit_idx;
  logic                         pend;
  logic                         hit;
  logic [AW-1:0]                clr_addr;

  logic                         div_start;
  logic                         div_done;
  logic [3:0]                   div_rem;
  logic [ummt_pkg::DIVD_W-1:0]  dividend;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [REC_W-1:0]             ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [REC_W-1:0]             ram_rdata;

  logic                         issue;
  logic                         cell_ok;
  logic                         hit_now;
  logic                         miss_end;
  logic                         slot_valid;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= ummt_pkg::TCNT_RESET;
    end else if (cfg_we) begin
      table_count <= cfg_data;
    end
  end

  // effective table count, zero taken as one and clamped to TABLES
  always_comb begin
    if (table_count == '0) begin
      tcount_eff = 4'd1;
    end else if (32'(table_count) > TABLES) begin
      tcount_eff = 4'(TABLES);
    end else begin
      tcount_eff = table_count;
    end
  end

  assign dividend = ummt_pkg::DIVD_W'(17'(request.communicator) + 17'(HIDDEN_TABLES));

  ummt_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (tcount_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  // record memory, busy bit in the same word; a write-back finishes before the
  // next command can issue a read, so no forwarding is needed
  ummt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rec = ummt_pkg::rec_t'(ram_rdata);
  assign slot_valid = 32'(req.slot) < CELLS;

  // hit test on the cell read back in this cycle
  always_comb begin
    case (req.action)
      ummt_pkg::ACT_PUSH:      cell_ok = !rd_rec.busy;
      ummt_pkg::ACT_PROBE,
      ummt_pkg::ACT_POP_MATCH: cell_ok = rd_rec.busy
                                   && (req.any_rank || rd_rec.rank == req.rank)
                                   && (req.any_tag || rd_rec.tag == req.tag);
      ummt_pkg::ACT_POP_SLOT:  cell_ok = rd_rec.busy;
      default:                 cell_ok = 1'b0;
    endcase
  end

  assign issue    = (state == ummt_pkg::ST_SCAN) && (scan_idx <= last_idx);
  assign hit_now  = pend && cell_ok;
  assign miss_end = pend && !cell_ok && (pend_idx == last_idx);

  // record written back: new record on push, busy dropped on a pop
  always_comb begin
    wr_rec = hit_rec;
    wr_rec.busy = 1'b0;
    if (req.action == ummt_pkg::ACT_PUSH) begin
      wr_rec.busy = 1'b1;
      wr_rec.rank = req.rank;
      wr_rec.tag  = req.tag;
      wr_rec.size = req.msg_bytes;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ummt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory control and result
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = '0;
    ram_re     = issue;
    ram_raddr  = AW'(int'(tbl) * CELLS + int'(scan_idx));
    done       = 1'b0;
    result     = '0;
    case (state)
      ummt_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == AW'(TOTAL - 1)) begin
          state_next = ummt_pkg::ST_IDLE;
        end
      end
      ummt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          div_start  = 1'b1;
          state_next = ummt_pkg::ST_MAP;
        end
      end
      ummt_pkg::ST_MAP: begin
        if (div_done) begin
          if (req.action == ummt_pkg::ACT_POP_SLOT && !slot_valid) begin
            state_next = ummt_pkg::ST_DONE;
          end else begin
            state_next = ummt_pkg::ST_SCAN;
          end
        end
      end
      ummt_pkg::ST_SCAN: begin
        if (hit_now || miss_end) begin
          state_next = ummt_pkg::ST_DONE;
        end
      end
      ummt_pkg::ST_DONE: begin
        done      = 1'b1;
        ram_we    = hit && (req.action != ummt_pkg::ACT_PROBE);
        ram_waddr = AW'(int'(tbl) * CELLS + int'(hit_idx));
        ram_wdata = REC_W'(wr_rec);
        result.found = hit;
        if (hit && req.action != ummt_pkg::ACT_PUSH) begin
          result.found_size = hit_rec.size;
        end
        if (req.action == ummt_pkg::ACT_POP_SLOT) begin
          result.found_slot = req.slot;
        end else if (hit) begin
          result.found_slot = ummt_pkg::SLOT_W'(hit_idx);
        end
        state_next = ummt_pkg::ST_IDLE;
      end
      default: begin
        state_next = ummt_pkg::ST_IDLE;
      end
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ummt_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      hit  <= 1'b0;
    end else begin
      case (state)
        ummt_pkg::ST_MAP: begin
          pend <= 1'b0;
          hit  <= 1'b0;
        end
        ummt_pkg::ST_SCAN: begin
          pend <= issue;
          if (hit_now || miss_end) begin
            hit <= hit_now;
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  // command beat, table index and scan pointers
  always_ff @(posedge clk) begin
    if (state == ummt_pkg::ST_IDLE && start) begin
      req <= request;
    end
    if (state == ummt_pkg::ST_MAP && div_done) begin
      tbl <= TW'(div_rem);
      if (req.action == ummt_pkg::ACT_POP_SLOT) begin
        scan_idx <= IW'(req.slot);
        last_idx <= IW'(req.slot);
      end else begin
        scan_idx <= '0;
        last_idx <= IW'(CELLS - 1);
      end
    end
    if (state == ummt_pkg::ST_SCAN) begin
      pend_idx <= scan_idx;
      if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (hit_now || miss_end) begin
        hit_idx <= pend_idx;
        hit_rec <= rd_rec;
      end
    end
  end

endmodule

// ===== verif/unexpected_message_match_table_core_tb.sv =====
// unexpected_message_match_table_core_tb: self-checking testbench of the message match table
// drives commands and table_count writes, predicts every result and compares field by field
// depends on ummt_pkg and unexpected_message_match_table_core
`timescale 1ns / 1ps

module unexpected_message_match_table_core_tb;

  localparam int CELLS           = 16;
  localparam int TABLES          = 8;
  localparam int HIDDEN_TABLES   = 4;
  localparam int RAND_PER_PHASE  = 230;
  localparam int DRAIN_CYCLES    = 40;
  localparam int WATCHDOG_CYCLES = 2000;

  // directed stimulus row, with the result typed in where it is obvious
  typedef struct {
    ummt_pkg::req_t cmd;
    bit             typed;
    ummt_pkg::rsp_t want;
  } cmd_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  ummt_pkg::req_t                request;
  logic                          done;
  ummt_pkg::rsp_t                result;
  logic                          cfg_we;
  logic [ummt_pkg::TCNT_W-1:0]   cfg_data;

  // side info that travels with the beat on the command port
  bit                            row_typed;
  ummt_pkg::rsp_t                row_want;

  // predicted match table contents and mapping register
  bit                            cell_occupied [TABLES*CELLS];
  logic [ummt_pkg::RANK_W-1:0]   held_rank [TABLES*CELLS];
  logic [ummt_pkg::TAG_W-1:0]    held_tag [TABLES*CELLS];
  logic [ummt_pkg::SIZE_W-1:0]   held_size [TABLES*CELLS];
  logic [ummt_pkg::TCNT_W-1:0]   table_count_m = ummt_pkg::TCNT_RESET;

  ummt_pkg::rsp_t  pending_results [$];
  int              mismatch_count = 0;
  int              stall_cycles = 0;
  int              burst_left = 0;
  int              cmd_count = 0;
  int              store_count = 0;
  int              full_count = 0;
  int              match_count = 0;
  int              slot_free_count = 0;

  // per-phase pools so that stored records are matched again
  logic [ummt_pkg::RANK_W-1:0] rank_pool [4];
  logic [ummt_pkg::TAG_W-1:0]  tag_pool [4];
  logic [ummt_pkg::COMM_W-1:0] comm_focus [3];

  unexpected_message_match_table_core #(
    .CELLS         (CELLS),
    .TABLES        (TABLES),
    .HIDDEN_TABLES (HIDDEN_TABLES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table lookup and update for one command, returns the expected result
  function automatic ummt_pkg::rsp_t apply_command(ummt_pkg::req_t r);
    ummt_pkg::rsp_t res;
    int   n;
    int   base;
    int   c;
    bit   hit;
    res = '0;
    hit = 1'b0;
    n = (table_count_m == 0) ? 1 : ((table_count_m > TABLES) ? TABLES : int'(table_count_m));
    base = ((int'(r.communicator) + HIDDEN_TABLES) % n) * CELLS;
    case (r.action)
      ummt_pkg::ACT_PUSH: begin
        for (int i = 0; i < CELLS; i++) begin
          c = base + i;
          if (!hit && !cell_occupied[c]) begin
            hit = 1'b1;
            cell_occupied[c] = 1'b1;
            held_rank[c] = r.rank;
            held_tag[c] = r.tag;
            held_size[c] = r.msg_bytes;
            res.found = 1'b1;
            res.found_slot = ummt_pkg::SLOT_W'(i);
          end
        end
        if (hit) store_count++;
        else full_count++;
      end
      ummt_pkg::ACT_PROBE, ummt_pkg::ACT_POP_MATCH: begin
        for (int i = 0; i < CELLS; i++) begin
          c = base + i;
          if (!hit && cell_occupied[c] && (r.any_rank || held_rank[c] == r.rank) &&
              (r.any_tag || held_tag[c] == r.tag)) begin
            hit = 1'b1;
            res.found = 1'b1;
            res.found_size = held_size[c];
            res.found_slot = ummt_pkg::SLOT_W'(i);
            if (r.action == ummt_pkg::ACT_POP_MATCH) cell_occupied[c] = 1'b0;
          end
        end
        if (hit) match_count++;
      end
      default: begin
        res.found_slot = r.slot;
        if (int'(r.slot) < CELLS) begin
          c = base + int'(r.slot);
          if (cell_occupied[c]) begin
            res.found = 1'b1;
            res.found_size = held_size[c];
            cell_occupied[c] = 1'b0;
            slot_free_count++;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic ummt_pkg::req_t make_cmd(ummt_pkg::action_t a,
                                              logic [ummt_pkg::COMM_W-1:0] comm,
                                              logic [ummt_pkg::RANK_W-1:0] rk, logic ar,
                                              logic [ummt_pkg::TAG_W-1:0] tg, logic at,
                                              logic [ummt_pkg::SIZE_W-1:0] sz,
                                              logic [ummt_pkg::SLOT_W-1:0] sl);
    ummt_pkg::req_t r;
    r.action = a;
    r.communicator = comm;
    r.rank = rk;
    r.any_rank = ar;
    r.tag = tg;
    r.any_tag = at;
    r.msg_bytes = sz;
    r.slot = sl;
    return r;
  endfunction

  // mode 0 fills tables, mode 1 matches and frees, anything else is raw noise
  function automatic ummt_pkg::req_t random_cmd(int mode, logic [ummt_pkg::COMM_W-1:0] comm);
    ummt_pkg::req_t r;
    logic [127:0]   raw;
    int             pick;
    pick = $urandom_range(0, 3);
    r.communicator = ($urandom_range(0, 9) == 0) ? ummt_pkg::COMM_W'($urandom) : comm;
    r.rank = rank_pool[pick];
    r.tag = ($urandom_range(0, 3) == 0) ? tag_pool[$urandom_range(0, 3)] : tag_pool[pick];
    r.any_rank = ($urandom_range(0, 3) == 0);
    r.any_tag = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 7))
      0: r.msg_bytes = '1;
      1: r.msg_bytes = '0;
      default: r.msg_bytes = $urandom;
    endcase
    r.slot = ummt_pkg::SLOT_W'($urandom_range(0, CELLS - 1));
    case (mode)
      0: r.action = ($urandom_range(0, 9) < 8) ? ummt_pkg::ACT_PUSH
                                               : ummt_pkg::action_t'($urandom_range(1, 3));
      1: r.action = ummt_pkg::action_t'($urandom_range(1, 3));
      default: begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(ummt_pkg::req_t)-1:0];
      end
    endcase
    return r;
  endfunction

  // present one command beat and hold it until the block takes it
  task automatic send_cmd(input ummt_pkg::req_t r, input bit typed,
                          input ummt_pkg::rsp_t want);
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender bursts with random gaps, now and then a long burst without gaps
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 24);
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // write the mapping register once the block has drained
  task automatic write_table_count(input logic [ummt_pkg::TCNT_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result check and command prediction at the active edge
  always @(posedge clk) begin
    ummt_pkg::rsp_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %p", $time, result);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, got %0d", $time, want.found, result.found);
            mismatch_count++;
          end
          if (result.found_size !== want.found_size) begin
            $display("%0t: found_size mismatch, expected 0x%08h, got 0x%08h",
                     $time, want.found_size, result.found_size);
            mismatch_count++;
          end
          if (result.found_slot !== want.found_slot) begin
            $display("%0t: found_slot mismatch, expected %0d, got %0d",
                     $time, want.found_slot, result.found_slot);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        want = apply_command(request);
        if (row_typed) want = row_want;
        pending_results.push_back(want);
        cmd_count++;
      end
      if (cfg_we) table_count_m = cfg_data;
    end
  end

  // watchdog on cycles without a result, an accepted command or a table_count write
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_CYCLES, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cmd_row_t                    rows [$];
    logic [ummt_pkg::TCNT_W-1:0] phase_count [8];
    ummt_pkg::rsp_t              none;
    int                          mode;
    int                          seq_left;
    logic [ummt_pkg::COMM_W-1:0] seq_comm;
    none = '0;
    phase_count = '{4'd15, 4'd0, 4'd1, 4'd8, 4'd3, 4'd6, 4'd12, 4'd5};
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    row_typed = 1'b0;
    row_want = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows at the reset table count: comm 0 and 8 share a table, 0xffff is another
    rows.push_back('{make_cmd(ummt_pkg::ACT_PROBE, 16'd0, '0, 1'b0, '0, 1'b0, '0, '0),
                     1'b1, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_POP_MATCH, 16'd0, '0, 1'b1, '0, 1'b1, '0, '0),
                     1'b1, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_POP_SLOT, 16'd0, '0, 1'b0, '0, 1'b0, '0, 4'd15),
                     1'b1, ummt_pkg::rsp_t'({1'b0, 32'd0, 4'd15})});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PUSH, 16'd0, '1, 1'b0, '1, 1'b0, '1, '0),
                     1'b1, ummt_pkg::rsp_t'({1'b1, 32'd0, 4'd0})});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PUSH, 16'd0, '0, 1'b0, '0, 1'b0, '0, '1),
                     1'b1, ummt_pkg::rsp_t'({1'b1, 32'd0, 4'd1})});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PUSH, 16'hffff, 31'd5, 1'b1, 31'd7, 1'b1,
                              32'd1234, '0),
                     1'b1, ummt_pkg::rsp_t'({1'b1, 32'd0, 4'd0})});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PROBE, 16'd0, '1, 1'b0, '1, 1'b0, '0, '0),
                     1'b1, ummt_pkg::rsp_t'({1'b1, 32'hffff_ffff, 4'd0})});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PROBE, 16'd0, '0, 1'b0, '1, 1'b0, '0, '0),
                     1'b0, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PROBE, 16'd0, '1, 1'b1, '0, 1'b0, '0, '0),
                     1'b0, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PROBE, 16'd8, '0, 1'b1, '0, 1'b1, '0, '0),
                     1'b0, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_POP_MATCH, 16'd0, '0, 1'b1, '1, 1'b0, '0, '0),
                     1'b0, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PUSH, 16'd0, 31'd1, 1'b0, 31'd2, 1'b0, 32'd3, '0),
                     1'b0, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_POP_SLOT, 16'd0, '0, 1'b0, '0, 1'b0, '0, 4'd1),
                     1'b0, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_POP_SLOT, 16'd0, '0, 1'b0, '0, 1'b0, '0, 4'd1),
                     1'b1, ummt_pkg::rsp_t'({1'b0, 32'd0, 4'd1})});
    rows.push_back('{make_cmd(ummt_pkg::ACT_POP_SLOT, 16'hffff, '0, 1'b0, '0, 1'b0, '0, 4'd0),
                     1'b0, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_POP_MATCH, 16'd0, 31'd1, 1'b0, '0, 1'b1, '0, '0),
                     1'b0, none});
    rows.push_back('{make_cmd(ummt_pkg::ACT_PROBE, 16'd0, '0, 1'b1, '0, 1'b1, '0, '0),
                     1'b0, none});
    foreach (rows[i]) begin
      send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
      pace_sender();
    end

    // random phases, one per table count setting
    foreach (phase_count[p]) begin
      write_table_count(phase_count[p]);
      rank_pool[0] = '0;
      rank_pool[1] = '1;
      rank_pool[2] = ummt_pkg::RANK_W'($urandom);
      rank_pool[3] = ummt_pkg::RANK_W'($urandom);
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      tag_pool[2] = ummt_pkg::TAG_W'($urandom);
      tag_pool[3] = ummt_pkg::TAG_W'($urandom);
      foreach (comm_focus[k]) comm_focus[k] = ummt_pkg::COMM_W'($urandom);
      seq_left = 0;
      mode = 0;
      seq_comm = '0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (seq_left == 0) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: mode = 0;
            7, 8, 9, 10, 11, 12, 13, 14: mode = 1;
            default: mode = 2;
          endcase
          seq_left = $urandom_range(1, 20);
          seq_comm = comm_focus[$urandom_range(0, 2)];
        end
        seq_left--;
        send_cmd(random_cmd(mode, seq_comm), 1'b0, none);
        pace_sender();
      end
    end

    // drain what is still in flight, then leave room for stray results
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands over %0d table count settings", cmd_count, 1 + $size(phase_count));
    $display("%0d stores, %0d full-table pushes, %0d matches, %0d frees by slot",
             store_count, full_count, match_count, slot_free_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
